/* hw/rtl/lpit_pkg.sv */
// package for the point-in-triangle locator
// payload structs, arithmetic widths and divider request/response types
// no dependencies
`timescale 1ns / 1ps
package lpit_pkg;

  // arithmetic widths
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned DIFF_W   = COORD_W + 1;
  localparam int unsigned PROD_W   = 2 * DIFF_W;
  localparam int unsigned CROSS_W  = PROD_W + 1;
  localparam int unsigned MAG_W    = PROD_W;
  localparam int unsigned FRAC_SH  = 24;
  localparam int unsigned QUO_W    = 32;
  localparam int unsigned TOL_W    = 25;
  localparam int unsigned IDX_W    = 24;
  localparam int unsigned TEST_W   = QUO_W + 3;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] corner0_x;
    logic signed [COORD_W-1:0] corner0_y;
    logic signed [COORD_W-1:0] corner1_x;
    logic signed [COORD_W-1:0] corner1_y;
    logic signed [COORD_W-1:0] corner2_x;
    logic signed [COORD_W-1:0] corner2_y;
    logic [IDX_W-1:0]          elem_index;
    logic                      last_candidate;
  } in_beat_t;

  typedef struct packed {
    logic                    found;
    logic [IDX_W-1:0]        hit_index;
    logic signed [QUO_W-1:0] coord_u;
    logic signed [QUO_W-1:0] coord_v;
    logic                    degenerate_seen;
  } out_beat_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] num_mag;
    logic [MAG_W-1:0] den_mag;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic             big;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

/* hw/rtl/lpit_div.sv */
// serial restoring divider, one quotient bit per cycle
// computes (num << 24) / den with an overflow flag for quotients >= 2^32
// depends on lpit_pkg
`timescale 1ns / 1ps
module lpit_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lpit_pkg::div_req_t req_i,
  output lpit_pkg::div_rsp_t rsp_o
);

  localparam int unsigned NW = lpit_pkg::MAG_W + lpit_pkg::FRAC_SH;
  localparam int unsigned RW = lpit_pkg::MAG_W + 1;
  localparam int unsigned CW = lpit_pkg::MAG_W + lpit_pkg::QUO_W;
  localparam int unsigned HW = NW - lpit_pkg::QUO_W;

  logic [NW-1:0]                num_ext;
  logic                         big_d;
  logic [RW-1:0]                rem_q, rem_d, rem_sh;
  logic [lpit_pkg::QUO_W-1:0]   lo_q, lo_d, quo_q, quo_d;
  logic [lpit_pkg::MAG_W-1:0]   den_q, den_d;
  logic [4:0]                   cnt_q, cnt_d;
  logic                         busy_q, busy_d, done_q, done_d, big_q;
  logic                         ge;

  // numerator scaled into Q66.24 and overflow precheck
  assign num_ext = {req_i.num_mag, {lpit_pkg::FRAC_SH{1'b0}}};
  assign big_d   = {{(CW-NW){1'b0}}, num_ext} >= {req_i.den_mag, {lpit_pkg::QUO_W{1'b0}}};

  // one restoring step
  assign rem_sh = {rem_q[RW-2:0], lo_q[lpit_pkg::QUO_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    lo_d   = lo_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = {{(RW-HW){1'b0}}, num_ext[NW-1:lpit_pkg::QUO_W]};
      lo_d   = num_ext[lpit_pkg::QUO_W-1:0];
      den_d  = req_i.den_mag;
      quo_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? rem_sh - {1'b0, den_q} : rem_sh;
      lo_d  = {lo_q[lpit_pkg::QUO_W-2:0], 1'b0};
      quo_d = {quo_q[lpit_pkg::QUO_W-2:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    lo_q  <= lo_d;
    quo_q <= quo_d;
    den_q <= den_d;
    if (req_i.start) begin
      big_q <= big_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.big  = big_q;
  assign rsp_o.quo  = quo_q;

endmodule

/* hw/rtl/locate_point_in_triangles.sv */
// point-in-triangle locator: a candidate is accepted only while idle, so not while
// one is in work; an examined candidate uses one shared 33x33 multiplier, then the
// shared serial divider for u and v, then a decision; a zero Jacobian skips the
// divides; a candidate after a hit is skipped; a stalled result holds the decision
// reset clears tolerance, hit and degenerate state and the result valid
// depends on lpit_pkg and lpit_div
`timescale 1ns / 1ps
module locate_point_in_triangles (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lpit_pkg::in_beat_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lpit_pkg::out_beat_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [lpit_pkg::TOL_W-1:0]    cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_DIV_U = 5'b00100,
    S_DIV_V = 5'b01000,
    S_RES   = 5'b10000
  } state_e;

  localparam int unsigned DW = lpit_pkg::DIFF_W;
  localparam int unsigned PW = lpit_pkg::PROD_W;
  localparam int unsigned XW = lpit_pkg::CROSS_W;
  localparam int unsigned QW = lpit_pkg::QUO_W;
  localparam int unsigned TW = lpit_pkg::TEST_W;

  state_e state_q, state_d;
  logic [lpit_pkg::TOL_W-1:0] tol_q;
  logic hit_q, degen_q, out_valid_q, last_q, jzero_q;
  logic [lpit_pkg::IDX_W-1:0] idx_q;
  logic signed [DW-1:0] d1x_q, d1y_q, d2x_q, d2y_q, dx_q, dy_q;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_q;
  logic signed [XW-1:0] jac_q, nu_q, nv_q, prod_ext;
  logic signed [QW-1:0] u_q, v_q, quo_sat;
  logic [2:0] step_q, acc_sel;
  logic quo_neg;
  lpit_pkg::div_req_t div_req;
  lpit_pkg::div_rsp_t div_rsp;
  lpit_pkg::out_beat_t out_q;
  logic in_fire, res_fire, in_tri, mul_end, jac_zero;
  logic signed [TW-1:0] u_t, v_t, t_t;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign mul_end    = (state_q == S_MUL) && (step_q == 3'd6);
  assign jac_zero   = (jac_q == '0);
  assign res_fire   = (state_q == S_RES) && (!out_valid_q || out_ready_i);

  // shared multiplier operand select
  always_comb begin
    unique case (step_q)
      3'd0:    begin mul_a = d1x_q; mul_b = d2y_q; end
      3'd1:    begin mul_a = d1y_q; mul_b = d2x_q; end
      3'd2:    begin mul_a = dx_q;  mul_b = d2y_q; end
      3'd3:    begin mul_a = dy_q;  mul_b = d2x_q; end
      3'd4:    begin mul_a = dy_q;  mul_b = d1x_q; end
      3'd5:    begin mul_a = dx_q;  mul_b = d1y_q; end
      default: begin mul_a = '0;    mul_b = '0;    end
    endcase
  end

  assign prod_ext = XW'(prod_q);
  assign acc_sel  = step_q - 3'd1;

  // divider request: u at the end of the products, v when u is done
  always_comb begin
    div_req.start   = 1'b0;
    div_req.num_mag = '0;
    div_req.den_mag = jac_q[XW-1] ? lpit_pkg::MAG_W'(-jac_q) : lpit_pkg::MAG_W'(jac_q);
    if (mul_end && !jac_zero) begin
      div_req.start   = 1'b1;
      div_req.num_mag = nu_q[XW-1] ? lpit_pkg::MAG_W'(-nu_q) : lpit_pkg::MAG_W'(nu_q);
    end else if (state_q == S_DIV_U && div_rsp.done) begin
      div_req.start   = 1'b1;
      div_req.num_mag = nv_q[XW-1] ? lpit_pkg::MAG_W'(-nv_q) : lpit_pkg::MAG_W'(nv_q);
    end
  end

  lpit_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sign and saturation of the quotient
  assign quo_neg = (state_q == S_DIV_U) ? (nu_q[XW-1] ^ jac_q[XW-1])
                                        : (nv_q[XW-1] ^ jac_q[XW-1]);
  always_comb begin
    if (quo_neg) begin
      if (div_rsp.big || (div_rsp.quo[QW-1] && (div_rsp.quo[QW-2:0] != '0))) begin
        quo_sat = {1'b1, {(QW-1){1'b0}}};
      end else begin
        quo_sat = -$signed(div_rsp.quo);
      end
    end else begin
      if (div_rsp.big || div_rsp.quo[QW-1]) begin
        quo_sat = {1'b0, {(QW-1){1'b1}}};
      end else begin
        quo_sat = $signed(div_rsp.quo);
      end
    end
  end

  // inside test with tolerance
  assign u_t = TW'(u_q);
  assign v_t = TW'(v_q);
  assign t_t = $signed({{(TW-lpit_pkg::TOL_W){1'b0}}, tol_q});
  assign in_tri = !jzero_q && !((u_t < -t_t) || (v_t < -t_t) ||
                  (u_t > (TW'(1) <<< lpit_pkg::FRAC_SH) + t_t - v_t));

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_fire && !hit_q) state_d = S_MUL;
      S_MUL:   if (mul_end) state_d = jac_zero ? S_RES : S_DIV_U;
      S_DIV_U: if (div_rsp.done) state_d = S_DIV_V;
      S_DIV_V: if (div_rsp.done) state_d = S_RES;
      S_RES:   if (res_fire) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tol_q       <= '0;
      hit_q       <= 1'b0;
      degen_q     <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        tol_q <= cfg_data_i;
      end
      if (in_fire) begin
        step_q <= '0;
      end else if (state_q == S_MUL) begin
        step_q <= step_q + 3'd1;
      end
      if (in_fire && hit_q && in_data_i.last_candidate) begin
        hit_q   <= 1'b0;
        degen_q <= 1'b0;
      end
      if (mul_end && jac_zero) begin
        degen_q <= 1'b1;
      end
      if (res_fire) begin
        if (last_q) begin
          hit_q   <= 1'b0;
          degen_q <= 1'b0;
        end else if (in_tri) begin
          hit_q <= 1'b1;
        end
      end
      if (res_fire && (in_tri || last_q)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      d1x_q  <= DW'(in_data_i.corner1_x) - DW'(in_data_i.corner0_x);
      d1y_q  <= DW'(in_data_i.corner1_y) - DW'(in_data_i.corner0_y);
      d2x_q  <= DW'(in_data_i.corner2_x) - DW'(in_data_i.corner0_x);
      d2y_q  <= DW'(in_data_i.corner2_y) - DW'(in_data_i.corner0_y);
      dx_q   <= DW'(in_data_i.point_x) - DW'(in_data_i.corner0_x);
      dy_q   <= DW'(in_data_i.point_y) - DW'(in_data_i.corner0_y);
      idx_q  <= in_data_i.elem_index;
      last_q <= in_data_i.last_candidate;
    end
    if (state_q == S_MUL) begin
      prod_q <= PW'(mul_a) * PW'(mul_b);
      unique case (acc_sel)
        3'd0:    jac_q <= prod_ext;
        3'd1:    jac_q <= jac_q - prod_ext;
        3'd2:    nu_q  <= prod_ext;
        3'd3:    nu_q  <= nu_q - prod_ext;
        3'd4:    nv_q  <= prod_ext;
        3'd5:    nv_q  <= nv_q - prod_ext;
        default: ;
      endcase
    end
    if (mul_end) begin
      jzero_q <= jac_zero;
    end
    if (state_q == S_DIV_U && div_rsp.done) begin
      u_q <= quo_sat;
    end
    if (state_q == S_DIV_V && div_rsp.done) begin
      v_q <= quo_sat;
    end
    if (res_fire) begin
      out_q.found           <= in_tri;
      out_q.hit_index       <= in_tri ? idx_q : '0;
      out_q.coord_u         <= in_tri ? u_q : '0;
      out_q.coord_v         <= in_tri ? v_q : '0;
      out_q.degenerate_seen <= degen_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV_U || state_q == S_DIV_V))
    else $error("divider finished outside a divide state");

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_rsp.busy)
    else $error("ready while divider busy");

  a_out_from_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_RES))
    else $error("result loaded outside the decision state");

endmodule

/* tb/testbench.sv */
// self-checking testbench for the point-in-triangle locator
// drives candidate beats, predicts located results and compares them field by field
// depends on lpit_pkg and locate_point_in_triangles
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam longint ONE_Q24 = 64'sd1 << 24;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lpit_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lpit_pkg::out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [lpit_pkg::TOL_W-1:0] cfg_data = '0;

  // candidates waiting to go and located results still owed
  lpit_pkg::in_beat_t candidate_q[$];
  lpit_pkg::out_beat_t located_q[$];

  // predictor state
  logic [lpit_pkg::TOL_W-1:0] tol_shadow = '0;
  bit hit_seen = 1'b0;
  bit degen_seen = 1'b0;

  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned hits = 0;
  int unsigned misses = 0;
  int unsigned degen_results = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  locate_point_in_triangles uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch %s: got %0h want %0h", what, got, want);
  endtask

  // signed (|num| << 24) / |den|, truncated toward zero, saturated to 32 bits
  function automatic longint q24_divide(input logic signed [127:0] num,
                                        input logic signed [127:0] den);
    logic [127:0] n_mag;
    logic [127:0] d_mag;
    logic [127:0] quo;
    bit neg;
    neg = num[127] ^ den[127];
    n_mag = num[127] ? -num : num;
    d_mag = den[127] ? -den : den;
    quo = (n_mag << 24) / d_mag;
    if (neg) return (quo > 128'h8000_0000) ? -64'sd2147483648 : -longint'(quo);
    return (quo > 128'h7FFF_FFFF) ? 64'sd2147483647 : longint'(quo);
  endfunction

  // barycentric test of one candidate, queues a result when one is due
  task automatic locate_candidate(input lpit_pkg::in_beat_t b);
    logic signed [127:0] d1x, d1y, d2x, d2y, dx, dy, jac;
    longint u, v, t;
    bit in_tri;
    lpit_pkg::out_beat_t r;
    in_tri = 1'b0;
    u = 0;
    v = 0;
    r = '0;
    if (hit_seen) begin
      if (b.last_candidate) begin
        hit_seen = 1'b0;
        degen_seen = 1'b0;
      end
      return;
    end
    d1x = longint'(b.corner1_x) - longint'(b.corner0_x);
    d1y = longint'(b.corner1_y) - longint'(b.corner0_y);
    d2x = longint'(b.corner2_x) - longint'(b.corner0_x);
    d2y = longint'(b.corner2_y) - longint'(b.corner0_y);
    dx = longint'(b.point_x) - longint'(b.corner0_x);
    dy = longint'(b.point_y) - longint'(b.corner0_y);
    jac = d1x * d2y - d1y * d2x;
    if (jac == 0) begin
      degen_seen = 1'b1;
    end else begin
      t = longint'(tol_shadow);
      u = q24_divide(dx * d2y - dy * d2x, jac);
      v = q24_divide(dy * d1x - dx * d1y, jac);
      in_tri = !(u < -t || v < -t || u > ONE_Q24 + t - v);
    end
    if (in_tri) begin
      r.found = 1'b1;
      r.hit_index = b.elem_index;
      r.coord_u = u[31:0];
      r.coord_v = v[31:0];
      r.degenerate_seen = degen_seen;
      located_q = {located_q, r};
      hit_seen = !b.last_candidate;
      if (b.last_candidate) degen_seen = 1'b0;
      hits++;
    end else if (b.last_candidate) begin
      r.degenerate_seen = degen_seen;
      located_q = {located_q, r};
      hit_seen = 1'b0;
      degen_seen = 1'b0;
      misses++;
    end
    if (r.degenerate_seen && (in_tri || b.last_candidate)) degen_results++;
  endtask

  // sender: one beat per queued candidate with a random gap after each
  always @(posedge clk_i) begin
    if (in_valid && in_ready) begin
      locate_candidate(in_data);
      beats_sent++;
      send_gap = quiet ? 0 : $urandom_range(0, 15);
    end
    if (!(in_valid && !in_ready)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (candidate_q.size() > 0 && rst_ni) begin
        in_data <= candidate_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: compare each result beat, then stall at random or on request
  always @(posedge clk_i) begin
    lpit_pkg::out_beat_t want;
    if (out_valid && out_ready) begin
      if (located_q.size() == 0) begin
        report_mismatch("unexpected result", longint'(out_data.hit_index), 0);
      end else begin
        want = located_q.pop_front();
        if (out_data.found !== want.found)
          report_mismatch("found", out_data.found, want.found);
        if (out_data.hit_index !== want.hit_index)
          report_mismatch("hit_index", out_data.hit_index, want.hit_index);
        if (out_data.coord_u !== want.coord_u)
          report_mismatch("coord_u", out_data.coord_u, want.coord_u);
        if (out_data.coord_v !== want.coord_v)
          report_mismatch("coord_v", out_data.coord_v, want.coord_v);
        if (out_data.degenerate_seen !== want.degenerate_seen)
          report_mismatch("degenerate_seen", out_data.degenerate_seen,
                          want.degenerate_seen);
      end
      recv_gap = quiet ? 0 : $urandom_range(0, 15);
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_ni;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic lpit_pkg::in_beat_t make_candidate(input bit aim_inside, input bit last,
                                                        input int unsigned shift);
    lpit_pkg::in_beat_t b;
    longint c0x, c0y, e1x, e1y, e2x, e2y, a, w;
    c0x = longint'($signed($urandom())) >>> shift;
    c0y = longint'($signed($urandom())) >>> shift;
    e1x = longint'($signed($urandom())) >>> (shift + 1);
    e1y = longint'($signed($urandom())) >>> (shift + 1);
    e2x = longint'($signed($urandom())) >>> (shift + 1);
    e2y = longint'($signed($urandom())) >>> (shift + 1);
    a = $urandom_range(0, 256);
    w = $urandom_range(0, 256 - a + 8);
    if (!aim_inside) begin
      a = longint'($urandom_range(0, 1200)) - 600;
      w = longint'($urandom_range(0, 1200)) - 600;
    end
    b.corner0_x = 32'(c0x);
    b.corner0_y = 32'(c0y);
    b.corner1_x = 32'(c0x + e1x);
    b.corner1_y = 32'(c0y + e1y);
    b.corner2_x = 32'(c0x + e2x);
    b.corner2_y = 32'(c0y + e2y);
    b.point_x = 32'(c0x + ((e1x * a + e2x * w) >>> 8));
    b.point_y = 32'(c0y + ((e1y * a + e2y * w) >>> 8));
    b.elem_index = 24'($urandom());
    b.last_candidate = last;
    return b;
  endfunction

  function automatic lpit_pkg::in_beat_t wild_candidate(input bit last);
    lpit_pkg::in_beat_t b;
    b = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
         $urandom(), $urandom(), 24'($urandom()), last};
    return b;
  endfunction

  function automatic lpit_pkg::in_beat_t degen_candidate(input bit last);
    lpit_pkg::in_beat_t b;
    b = make_candidate(1'b1, last, 4);
    b.corner2_x = b.corner1_x;
    b.corner2_y = b.corner1_y;
    return b;
  endfunction

  // wait for an idle block, then write the tolerance
  task automatic set_tolerance(input logic [lpit_pkg::TOL_W-1:0] tol);
    while (candidate_q.size() > 0 || in_valid || located_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_data <= tol;
    cfg_we <= 1'b1;
    tol_shadow = tol;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_point_group(input int unsigned count);
    int unsigned k;
    int unsigned pick;
    bit last;
    for (k = 0; k < count; k++) begin
      last = (k == count - 1);
      pick = $urandom_range(0, 19);
      if (pick == 0) candidate_q = {candidate_q, wild_candidate(last)};
      else if (pick == 1) candidate_q = {candidate_q, degen_candidate(last)};
      else candidate_q = {candidate_q,
                          make_candidate(pick > 9, last, $urandom_range(0, 12))};
    end
  endtask

  initial begin
    lpit_pkg::in_beat_t b;
    int unsigned phase;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, degenerate, not found, hit then skipped, hit on last
    b = '1;
    b.last_candidate = 1'b1;
    candidate_q = {candidate_q, b};
    b = '0;
    b.last_candidate = 1'b1;
    candidate_q = {candidate_q, b};
    b = '0;
    b.corner0_x = 32'sh8000_0000;
    b.corner0_y = 32'sh7FFF_FFFF;
    b.corner1_x = 32'sh7FFF_FFFF;
    b.corner1_y = 32'sh8000_0000;
    b.corner2_x = 32'sh7FFF_FFFF;
    b.corner2_y = 32'sh7FFF_FFFF;
    b.point_x = 32'sh8000_0000;
    b.point_y = 32'sh8000_0000;
    b.elem_index = 24'hFFFFFF;
    b.last_candidate = 1'b1;
    candidate_q = {candidate_q, b};
    b.point_x = 32'sh7FFF_FFFF;
    b.point_y = 32'sh7FFF_FFFF;
    b.corner2_x = 32'sh8000_0001;
    candidate_q = {candidate_q, b};
    candidate_q = {candidate_q, degen_candidate(1'b1)};
    candidate_q = {candidate_q, degen_candidate(1'b0)};
    candidate_q = {candidate_q, make_candidate(1'b1, 1'b0, 8)};
    candidate_q = {candidate_q, make_candidate(1'b1, 1'b0, 8)};
    candidate_q = {candidate_q, degen_candidate(1'b1)};
    candidate_q = {candidate_q, make_candidate(1'b0, 1'b0, 2)};
    candidate_q = {candidate_q, wild_candidate(1'b0)};
    candidate_q = {candidate_q, make_candidate(1'b0, 1'b1, 2)};
    candidate_q = {candidate_q, make_candidate(1'b1, 1'b1, 0)};
    candidate_q = {candidate_q, make_candidate(1'b1, 1'b1, 14)};

    // random groups over several tolerance settings, extremes included
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_tolerance('0);
        1: set_tolerance(25'd16777216);
        2: set_tolerance(25'd1);
        3: set_tolerance(25'($urandom_range(0, 65535)));
        4: set_tolerance(25'($urandom_range(0, 16777216)));
        default: set_tolerance('0);
      endcase
      quiet = (phase == 2);
      if (phase == 3) hold_req = 1'b1;
      while (beats_sent + candidate_q.size() < 14 + (phase + 1) * 206)
        queue_point_group($urandom_range(1, 6));
    end

    while (candidate_q.size() > 0 || in_valid || located_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d candidate beats: %0d hits, %0d not found, %0d with degenerate seen",
             beats_sent, hits, misses, degen_results);
    $display("tolerance settings from zero to full scale, with stalls on both sides");
    if (mismatches == 0 && located_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* locate_point_in_triangles.f */
hw/rtl/lpit_pkg.sv
hw/rtl/lpit_div.sv
hw/rtl/locate_point_in_triangles.sv
tb/testbench.sv
